// ===== rtl/core/sper_pkg.sv =====
// ----------------------------------------------------------------------------
// sper_pkg
// Shared types, codes and widths of the shortest-path edge relaxer.
// ----------------------------------------------------------------------------
package sper_pkg;

    // table geometry, fixed by the 8-bit node fields
    localparam int NODE_W        = 8;
    localparam int MAX_NODES     = 256;
    localparam int COUNT_W       = 9;
    localparam int DIST_BITS_DEF = 32;
    localparam int WEIGHT_W      = 16;
    localparam int DIST_OUT_W    = 32;
    localparam int CNT_W         = 32;
    localparam int KIND_W        = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELAX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STATS = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_START_NODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd1;
    localparam logic [COUNT_W-1:0]   NODE_COUNT_RST = 9'd256;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_FIELD_W = 108;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // one request as held while it executes
    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [NODE_W-1:0]          from_node;
        logic [NODE_W-1:0]          to_node;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } item_t;

endpackage

// ===== rtl/core/sper_relax_unit.sv =====
// ----------------------------------------------------------------------------
// sper_relax_unit
// Saturating distance + weight, and the strict improvement test.
// ----------------------------------------------------------------------------
module sper_relax_unit #(
    parameter int DIST_BITS = sper_pkg::DIST_BITS_DEF
) (
    input  logic signed [DIST_BITS-1:0]          dist_from,
    input  logic signed [DIST_BITS-1:0]          dist_to,
    input  logic signed [sper_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic                                 reach_to,
    output logic signed [DIST_BITS-1:0]          sum,
    output logic                                 better
);
    import sper_pkg::*;

    localparam int SUM_W = ((DIST_BITS > WEIGHT_W) ? DIST_BITS : WEIGHT_W) + 1;
    localparam logic signed [SUM_W-1:0] DMAX = SUM_W'({1'b0, {(DIST_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

    logic signed [SUM_W-1:0] raw;

    assign raw = SUM_W'(dist_from) + SUM_W'(edge_weight);

    always_comb
    begin
        if (raw > DMAX)
        begin
            sum = DMAX[DIST_BITS-1:0];
        end
        else if (raw < DMIN)
        begin
            sum = DMIN[DIST_BITS-1:0];
        end
        else
        begin
            sum = raw[DIST_BITS-1:0];
        end
    end

    // unreachable destination takes any sum
    assign better = !reach_to || (sum < dist_to);

endmodule

// ===== rtl/core/shortest_path_edge_relaxer.sv =====
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxer
// Distance / predecessor table for single-source shortest paths.
// ----------------------------------------------------------------------------
// When a request is accepted the distance memory is read at from_node and
// to_node and the predecessor memory at to_node into registers; in the
// execute state the saturating sum is formed, compared, written back and the
// result loaded into the output register. A new request is taken only in
// the idle state and when the output register is empty or its result leaves
// in the same cycle, so the block takes no new request while one executes
// and a stalled result holds off the next request. Request kinds: init (all
// nodes unreachable, start node at distance 0 when inside the table,
// relaxation count cleared), relax (edge test and update, edge count
// bumped), read (report to_node), statistics reset (both counters
// cleared). Every request returns one result describing to_node
// after the request. Reachable and predecessor flags sit in flip-flops and are
// cleared at once on init or reset; the distance and predecessor memories are
// never cleared and are only read where a flag says the entry is live.
// Configuration (start_node, node_count) may only be written while idle.
// ----------------------------------------------------------------------------
module shortest_path_edge_relaxer #(
    parameter int DIST_BITS = sper_pkg::DIST_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] from_node, [15:8] to_node, [31:16] edge_weight
    input  logic [sper_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] kind
    input  logic [sper_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] improved, [1] skipped, [33:2] distance, [34] reachable,
    // [35] has_predecessor, [43:36] predecessor, [75:44] relax_total,
    // [107:76] edge_total, [111:108] zero
    output logic [sper_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                                cfg_we,
    input  logic [sper_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sper_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sper_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    // configuration
    logic [NODE_W-1:0]  start_node_reg;
    logic [COUNT_W-1:0] node_count_reg;

    // held request and memory read data
    item_t                       item_reg;
    item_t                       in_item;
    logic signed [DIST_BITS-1:0] dist_from_reg;
    logic signed [DIST_BITS-1:0] dist_to_reg;
    logic [NODE_W-1:0]           pred_rd_reg;

    // tables
    logic signed [DIST_BITS-1:0] dist_mem [MAX_NODES];
    logic [NODE_W-1:0]           pred_mem [MAX_NODES];
    logic [MAX_NODES-1:0]        reach_reg, reach_next;
    logic [MAX_NODES-1:0]        predf_reg, predf_next;

    // counters
    logic [CNT_W-1:0] relax_cnt_reg, relax_cnt_next;
    logic [CNT_W-1:0] edge_cnt_reg, edge_cnt_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // execute-stage signals
    logic                        in_req;
    logic                        exec;
    logic                        is_init, is_relax, is_stats;
    logic                        from_ok, to_ok, start_ok;
    logic                        skip, improve;
    logic signed [DIST_BITS-1:0] sum;
    logic                        better;
    logic                        reach_after, predf_after;
    logic signed [DIST_BITS-1:0] dist_after;
    logic signed [63:0]          dist_wide;
    logic [NODE_W-1:0]           pred_after;
    logic                        dist_we;
    logic [NODE_W-1:0]           dist_waddr;
    logic signed [DIST_BITS-1:0] dist_wdata;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_item.kind        = s_axis_tuser;
    assign in_item.from_node   = s_axis_tdata[7:0];
    assign in_item.to_node     = s_axis_tdata[15:8];
    assign in_item.edge_weight = s_axis_tdata[31:16];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign exec = (state_reg == ST_EXEC);

    // ------------------------------------------------------------------
    // edge test
    // ------------------------------------------------------------------
    assign is_init  = (item_reg.kind == KIND_INIT);
    assign is_relax = (item_reg.kind == KIND_RELAX);
    assign is_stats = (item_reg.kind == KIND_STATS);

    assign from_ok  = {1'b0, item_reg.from_node} < node_count_reg;
    assign to_ok    = {1'b0, item_reg.to_node} < node_count_reg;
    assign start_ok = {1'b0, start_node_reg} < node_count_reg;

    assign skip    = !from_ok || !to_ok || !reach_reg[item_reg.from_node];
    assign improve = is_relax && !skip && better;

    sper_relax_unit #(
        .DIST_BITS (DIST_BITS)
    ) u_relax (
        .dist_from   (dist_from_reg),
        .dist_to     (dist_to_reg),
        .edge_weight (item_reg.edge_weight),
        .reach_to    (reach_reg[item_reg.to_node]),
        .sum         (sum),
        .better      (better)
    );

    // ------------------------------------------------------------------
    // flags, counters and write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        reach_next     = reach_reg;
        predf_next     = predf_reg;
        relax_cnt_next = relax_cnt_reg;
        edge_cnt_next  = edge_cnt_reg;
        dist_we        = 1'b0;
        dist_waddr     = item_reg.to_node;
        dist_wdata     = sum;
        if (exec)
        begin
            if (is_init)
            begin
                reach_next     = '0;
                predf_next     = '0;
                relax_cnt_next = '0;
                if (start_ok)
                begin
                    reach_next[start_node_reg] = 1'b1;
                    dist_we    = 1'b1;
                    dist_waddr = start_node_reg;
                    dist_wdata = '0;
                end
            end
            else if (is_relax)
            begin
                edge_cnt_next = edge_cnt_reg + 1'b1;
                if (improve)
                begin
                    reach_next[item_reg.to_node] = 1'b1;
                    predf_next[item_reg.to_node] = 1'b1;
                    relax_cnt_next = relax_cnt_reg + 1'b1;
                    dist_we = 1'b1;
                end
            end
            else if (is_stats)
            begin
                relax_cnt_next = '0;
                edge_cnt_next  = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result: to_node after the request
    // ------------------------------------------------------------------
    assign reach_after = reach_next[item_reg.to_node];
    assign predf_after = predf_next[item_reg.to_node];

    always_comb
    begin
        if (!reach_after || is_init)
        begin
            dist_after = '0;
        end
        else if (improve)
        begin
            dist_after = sum;
        end
        else
        begin
            dist_after = dist_to_reg;
        end

        if (!predf_after)
        begin
            pred_after = '0;
        end
        else if (improve)
        begin
            pred_after = item_reg.from_node;
        end
        else
        begin
            pred_after = pred_rd_reg;
        end
    end

    assign dist_wide = 64'(dist_after);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {
                {OUT_PAD_W{1'b0}},
                edge_cnt_next,
                relax_cnt_next,
                pred_after,
                predf_after,
                reach_after,
                dist_wide[DIST_OUT_W-1:0],
                is_relax && skip,
                improve
            };
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            reach_reg      <= '0;
            predf_reg      <= '0;
            relax_cnt_reg  <= '0;
            edge_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            start_node_reg <= '0;
            node_count_reg <= NODE_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            reach_reg     <= reach_next;
            predf_reg     <= predf_next;
            relax_cnt_reg <= relax_cnt_next;
            edge_cnt_reg  <= edge_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_NODE: start_node_reg <= cfg_data[NODE_W-1:0];
                    REG_NODE_COUNT: node_count_reg <= cfg_data[COUNT_W-1:0];
                    default:        start_node_reg <= start_node_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // memories: two reads of distance, one of predecessor, one write each
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            item_reg      <= in_item;
            dist_from_reg <= dist_mem[in_item.from_node];
            dist_to_reg   <= dist_mem[in_item.to_node];
            pred_rd_reg   <= pred_mem[in_item.to_node];
        end
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (improve && exec)
        begin
            pred_mem[item_reg.to_node] <= item_reg.from_node;
        end
    end

endmodule

// ===== rtl/core/sper_checker.sv =====
// ----------------------------------------------------------------------------
// sper_checker
// Port-level checks of the edge relaxer, bound to the top level.
// ----------------------------------------------------------------------------
module sper_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sper_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sper_pkg::*;

    logic in_req;

    assign in_req = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !s_axis_tready)
        else $error("request taken while busy");

    // result follows the request through the execute state into the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |-> ##2 m_axis_tvalid)
        else $error("result missing");

    // improved and skipped exclude each other
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("improved and skipped together");

    // an improved node is reachable with a predecessor
    a_improved: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[34] && m_axis_tdata[35])
        else $error("improved node lacks reach or predecessor");

endmodule

bind shortest_path_edge_relaxer sper_checker u_sper_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-path edge relaxer. Requests go in on
// the slave stream. An in-bench predictor keeps its own distance,
// predecessor and counter state and queues the expected result for each
// accepted request. Results from the master stream are checked field by
// field, in order. Both streams idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import sper_pkg::*;

    // generous guard against a run that hangs
    localparam int CYCLE_LIMIT   = 2_000_000;
    // settle time after the last result; one result per request
    localparam int SETTLE_CYCLES = 8;
    localparam longint DIST_HI = 64'sd2147483647;
    localparam longint DIST_LO = -64'sd2147483648;

    // result word, most significant field first so that it overlays m_axis_tdata
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [31:0]          edge_total;
        logic [31:0]          relax_total;
        logic [7:0]           predecessor;
        logic                 has_predecessor;
        logic                 reachable;
        logic [31:0]          distance;
        logic                 skipped;
        logic                 improved;
    } relax_result_t;

    // ------------------------------------------------------------------------
    // Predictor and result checker
    // ------------------------------------------------------------------------
    class path_scoreboard;
        logic [NODE_W-1:0]  start_node;
        logic [COUNT_W-1:0] node_count;
        logic signed [31:0] dist_mem [MAX_NODES];
        bit                 reach [MAX_NODES];
        logic [7:0]         pred_mem [MAX_NODES];
        bit                 has_pred [MAX_NODES];
        bit [31:0]          relax_cnt;
        bit [31:0]          edge_cnt;
        relax_result_t      expected_q [$];
        int                 errors;
        int                 results_seen;
        int                 improvements;
        int                 skips;
        int                 saturations;

        function new();
            start_node = '0;
            node_count = NODE_COUNT_RST;
            foreach (reach[i])
            begin
                dist_mem[i] = '0;
                reach[i]    = 1'b0;
                pred_mem[i] = '0;
                has_pred[i] = 1'b0;
            end
            relax_cnt = '0;
            edge_cnt  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_START_NODE)
                start_node = val[NODE_W-1:0];
            else if (idx == REG_NODE_COUNT)
                node_count = val;
        endfunction

        function int members();
            return (node_count < MAX_NODES) ? int'(node_count) : MAX_NODES;
        endfunction

        // source distance plus weight, clamped to the 32-bit signed range
        function logic signed [31:0] sat_sum(logic signed [31:0] d, logic signed [15:0] w);
            longint s;
            s = longint'(d) + longint'(w);
            if (s > DIST_HI)
            begin
                saturations++;
                return DIST_HI[31:0];
            end
            if (s < DIST_LO)
            begin
                saturations++;
                return DIST_LO[31:0];
            end
            return s[31:0];
        endfunction

        function void init_table();
            foreach (reach[i])
            begin
                reach[i]    = 1'b0;
                has_pred[i] = 1'b0;
            end
            relax_cnt = '0;
            // a start node outside the table leaves everything unreachable
            if (start_node < members())
            begin
                dist_mem[start_node] = '0;
                reach[start_node]    = 1'b1;
            end
        endfunction

        // apply one accepted request and queue the result it must produce
        function void note_request(item_t req);
            relax_result_t      r;
            int                 n;
            logic signed [31:0] s;
            r = '0;
            case (req.kind)
                KIND_INIT:
                    init_table();
                KIND_RELAX:
                begin
                    edge_cnt++;
                    n = members();
                    if (req.from_node >= n || req.to_node >= n || !reach[req.from_node])
                    begin
                        r.skipped = 1'b1;
                        skips++;
                    end
                    else
                    begin
                        s = sat_sum(dist_mem[req.from_node], req.edge_weight);
                        if (!reach[req.to_node] || s < dist_mem[req.to_node])
                        begin
                            dist_mem[req.to_node] = s;
                            reach[req.to_node]    = 1'b1;
                            pred_mem[req.to_node] = req.from_node;
                            has_pred[req.to_node] = 1'b1;
                            relax_cnt++;
                            r.improved = 1'b1;
                            improvements++;
                        end
                    end
                end
                KIND_STATS:
                begin
                    relax_cnt = '0;
                    edge_cnt  = '0;
                end
                default: ;
            endcase
            if (reach[req.to_node])
            begin
                r.distance  = dist_mem[req.to_node];
                r.reachable = 1'b1;
            end
            if (has_pred[req.to_node])
            begin
                r.has_predecessor = 1'b1;
                r.predecessor     = pred_mem[req.to_node];
            end
            r.relax_total = relax_cnt;
            r.edge_total  = edge_cnt;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            // keep the log readable when the block is badly off
            if (errors <= 50)
                $display("ERROR: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(relax_result_t got);
            relax_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with no request outstanding",
                                 results_seen));
                return;
            end
            want = expected_q.pop_front();
            check_field("improved", got.improved, want.improved);
            check_field("skipped", got.skipped, want.skipped);
            check_field("distance", got.distance, want.distance);
            check_field("reachable", got.reachable, want.reachable);
            check_field("has_predecessor", got.has_predecessor, want.has_predecessor);
            check_field("predecessor", got.predecessor, want.predecessor);
            check_field("relax_total", got.relax_total, want.relax_total);
            check_field("edge_total", got.edge_total, want.edge_total);
            check_field("padding", got.pad, want.pad);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;   // [7:0] from, [15:8] to, [31:16] weight
    logic [IN_TUSER_W-1:0]    s_axis_tuser;   // [1:0] kind
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;   // see relax_result_t
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    path_scoreboard sb;
    bit             quiet;          // suppresses idling on both streams
    int unsigned    cycle_count = 0;
    int             requests_sent;
    int             settings_used;

    shortest_path_edge_relaxer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length for either stream: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge in one process, so
    // the result is checked before the request of the same edge is noted.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_t req;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                req.kind        = s_axis_tuser;
                req.from_node   = s_axis_tdata[7:0];
                req.to_node     = s_axis_tdata[15:8];
                req.edge_weight = s_axis_tdata[31:16];
                sb.note_request(req);
            end
        end
    end

    // Result side back-pressure, changed on the falling edge.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            n = idle_len();
            if (n != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. Called and returns on a falling edge; tvalid stays high
    // between back-to-back requests and only drops for a gap.
    // ------------------------------------------------------------------------
    task automatic send_request(logic [KIND_W-1:0] kind, logic [7:0] src,
                                logic [7:0] dst, logic [15:0] w);
        int n;
        n = idle_len();
        if (n != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = {w, dst, src};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        requests_sent++;
    endtask

    // Stop sending until every outstanding result is back.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // registers only change with the block idle
    task automatic new_setting(logic [CFG_DATA_W-1:0] st, logic [CFG_DATA_W-1:0] cnt);
        drain();
        write_reg(REG_START_NODE, st);
        write_reg(REG_NODE_COUNT, cnt);
        settings_used++;
    endtask

    // a reachable member node where one exists, so that relaxations land
    function automatic logic [7:0] pick_source();
        int live [$];
        int n;
        n = sb.members();
        for (int i = 0; i < n; i++)
            if (sb.reach[i])
                live.push_back(i);
        if (live.size() == 0)
            return 8'($urandom_range(0, 255));
        return 8'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 60)
            v = int'($urandom_range(0, 120)) - 20;
        else if (r < 85)
            v = int'($urandom_range(0, 3300)) - 300;
        else
            v = int'($urandom_range(0, 65535));
        return v[15:0];
    endfunction

    // One random request: mostly relaxations out of the reachable set,
    // plus reads, stray edges, raw noise, re-inits and statistics resets.
    task automatic random_request();
        int         r;
        int         n;
        logic [7:0] dst;
        r   = $urandom_range(0, 99);
        n   = sb.members();
        dst = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, n - 1));
        if (r < 62)
            send_request(KIND_RELAX, pick_source(), dst, pick_weight());
        else if (r < 72)
            send_request(KIND_W'($urandom_range(0, 3)), 8'($urandom()),
                         8'($urandom()), 16'($urandom()));
        else if (r < 86)
            send_request(KIND_READ, 8'($urandom()),
                         ($urandom_range(0, 1) != 0) ? pick_source() : dst, 16'($urandom()));
        else if (r < 93)
            send_request(KIND_RELAX, 8'($urandom_range(0, 255)), dst, pick_weight());
        else if (r < 97)
            send_request(KIND_INIT, 8'($urandom()), 8'($urandom()), 16'($urandom()));
        else
            send_request(KIND_STATS, 8'($urandom()), dst, 16'($urandom()));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] st;
        logic [CFG_DATA_W-1:0] cnt;
        int                    pairs;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet         = 1'b0;
        requests_sent = 0;
        settings_used = 1;
        sb            = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed: reset settings, start 0, all 256 nodes in the table
        send_request(KIND_RELAX, 8'd0, 8'd1, 16'd5);        // before any init: skipped, counted
        send_request(KIND_READ, 8'hAA, 8'd255, 16'h5555);   // unreachable node reads as zero
        send_request(KIND_INIT, 8'hFF, 8'd0, 16'hFFFF);
        send_request(KIND_READ, 8'd0, 8'd0, 16'h0000);      // start node at zero, no predecessor
        send_request(KIND_RELAX, 8'd0, 8'd255, 16'h7FFF);   // unreachable destination, top weight
        send_request(KIND_RELAX, 8'd255, 8'd0, 16'h8000);   // bottom weight, lowers the start node
        send_request(KIND_RELAX, 8'd0, 8'd255, 16'h0000);
        send_request(KIND_RELAX, 8'd0, 8'd255, 16'h0000);   // equal sum is not an improvement
        send_request(KIND_RELAX, 8'd1, 8'd2, 16'd7);        // unreachable source: skipped
        send_request(KIND_RELAX, 8'd0, 8'd200, 16'd9);
        send_request(KIND_STATS, 8'd0, 8'd255, 16'h0000);
        send_request(KIND_READ, 8'd0, 8'd255, 16'h0000);

        // shrink the table without re-init: stale entries stay readable
        new_setting(9'd0, 9'd1);
        send_request(KIND_READ, 8'd0, 8'd200, 16'h0000);
        send_request(KIND_RELAX, 8'd0, 8'd200, 16'hFFFF);   // destination outside the table
        send_request(KIND_RELAX, 8'd200, 8'd0, 16'hFFFF);   // source outside the table
        send_request(KIND_INIT, 8'd0, 8'd0, 16'h0000);
        send_request(KIND_RELAX, 8'd0, 8'd0, 16'hFFFB);     // self loop in a one-node table

        // start node outside the table: init leaves every node unreachable
        new_setting(9'd255, 9'd1);
        send_request(KIND_INIT, 8'd0, 8'd0, 16'h0000);
        send_request(KIND_READ, 8'd0, 8'd255, 16'h0000);
        send_request(KIND_RELAX, 8'd255, 8'd0, 16'h0001);

        // highest start node in a full table
        new_setting(9'd255, 9'd256);
        send_request(KIND_INIT, 8'd0, 8'd0, 16'h0000);
        send_request(KIND_RELAX, 8'd255, 8'd0, 16'hFFFF);
        send_request(KIND_READ, 8'd0, 8'd0, 16'h0000);

        // ---- two-node negative cycle, back to back with no idling; every
        // pass lowers both distances again
        quiet = 1'b1;
        new_setting(9'd0, 9'd2);
        send_request(KIND_INIT, 8'd0, 8'd0, 16'h0000);
        for (pairs = 0; pairs < 12; pairs++)
        begin
            send_request(KIND_RELAX, 8'd0, 8'd1, 16'h8000);
            send_request(KIND_RELAX, 8'd1, 8'd0, 16'h8000);
        end
        send_request(KIND_READ, 8'd0, 8'd1, 16'h0000);
        quiet = 1'b0;

        // ---- random phases over a spread of register settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin st = 9'd0;   cnt = 9'd256; end
                1: begin st = 9'd255; cnt = 9'd256; end
                2:
                begin
                    cnt = 9'd16;
                    st  = 9'($urandom_range(0, 15));
                end
                3:
                begin
                    cnt = 9'($urandom_range(1, 256));
                    st  = 9'($urandom_range(0, 255));
                end
                4: begin st = 9'd1;   cnt = 9'd2;   end
                default:
                begin
                    cnt = 9'($urandom_range(2, 64));
                    st  = 9'($urandom_range(0, cnt - 1));
                end
            endcase
            new_setting(st, cnt);
            // last phase runs without idling on either side
            quiet = (p == 5);
            send_request(KIND_INIT, 8'($urandom()), 8'($urandom()), 16'($urandom()));
            repeat (133) random_request();
        end
        quiet = 1'b0;

        // ---- wind down
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

        $display("Run covered %0d requests under %0d register settings; %0d results checked.",
                 requests_sent, settings_used, sb.results_seen);
        $display("Edges: %0d improved, %0d skipped, %0d sums clamped at the distance limit.",
                 sb.improvements, sb.skips, sb.saturations);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
